### hdl/hfd_pkg.sv
// shared types, constants and crc helper for the humidity/temperature frame decoder
package hfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // frame byte positions
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // scaling: value = floor(scale * raw / 65535), temperature minus offset
  localparam int unsigned  SCALE_W     = 15;
  localparam int unsigned  RAW_W       = 16;
  localparam int unsigned  PROD_W      = SCALE_W + RAW_W;
  localparam logic [SCALE_W-1:0] TEMP_SCALE = 15'd17500;
  localparam logic [SCALE_W-1:0] HUM_SCALE  = 15'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic signed [15:0] TEMP_MIN    = -16'sd4500;
  localparam logic signed [15:0] TEMP_MAX    = 16'sd13000;
  localparam logic [13:0]        HUM_MAX     = 14'd10000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    status_e            status;
  } hfd_result_t;

  // one byte of crc-8, msb first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### hdl/hfd_frame.sv
// frame tracking, crc check and measurement scaling for one byte beat
module hfd_frame import hfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  output logic        last_o,
  output hfd_result_t res_o
);

  logic [2:0]              pos_q, pos_d, pos_eff;
  logic [7:0]              crc_q, crc_d, crc_in, crc_next;
  logic [7:0]              hi_q, hi_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    tfail_q, tfail_d;
  logic signed [14:0]      temp_q, temp_d;
  logic [13:0]             hum_q, hum_d;
  logic [RAW_W-1:0]        raw;
  logic [SCALE_W-1:0]      scale;
  logic [PROD_W:0]         div_sum;
  logic [15:0]             quot;
  logic signed [15:0]      temp_wide;
  logic                    match;
  logic                    hum_take;

  always_comb begin
    pos_eff = (start_i || (pos_q > POS_H_CRC)) ? POS_T_MSB : pos_q;
    crc_in  = ((pos_eff == POS_T_MSB) || (pos_eff == POS_H_MSB)) ? CRC_INIT : crc_q;
    crc_next = crc8_byte(crc_in, byte_i);
    match   = (crc_q == byte_i);
    raw     = {hi_q, byte_i};
    scale   = (pos_eff == POS_T_LSB) ? TEMP_SCALE : HUM_SCALE;
    // x / 65535 = (x + (x >> 16) + 1) >> 16 for x below 2^32 - 1
    div_sum = {1'b0, prod_q} + {{(PROD_W + 1 - (PROD_W - 16)){1'b0}}, prod_q[PROD_W-1:16]}
            + {{PROD_W{1'b0}}, 1'b1};
    quot      = div_sum[PROD_W:PROD_W-15];
    temp_wide = $signed({1'b0, quot[14:0]}) - TEMP_OFFSET;
    hum_take  = !tfail_q && match;
  end

  always_comb begin
    pos_d   = (pos_eff >= POS_H_CRC) ? POS_T_MSB : pos_eff + 3'd1;
    crc_d   = crc_q;
    hi_d    = hi_q;
    prod_d  = prod_q;
    tfail_d = tfail_q;
    temp_d  = temp_q;
    hum_d   = hum_q;
    unique case (pos_eff)
      POS_T_MSB, POS_H_MSB: begin
        crc_d = crc_next;
        hi_d  = byte_i;
      end
      POS_T_LSB, POS_H_LSB: begin
        crc_d  = crc_next;
        prod_d = {{(PROD_W - RAW_W){1'b0}}, raw} * {{(PROD_W - SCALE_W){1'b0}}, scale};
      end
      POS_T_CRC: begin
        crc_d = CRC_INIT;
        if (match) begin
          temp_d  = temp_wide[14:0];
          tfail_d = 1'b0;
        end else begin
          tfail_d = 1'b1;
        end
      end
      POS_H_CRC: begin
        crc_d = CRC_INIT;
        if (hum_take) begin
          hum_d = quot[13:0];
        end
      end
      default: begin
        crc_d = CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_T_MSB;
      crc_q   <= CRC_INIT;
      tfail_q <= 1'b0;
      temp_q  <= '0;
      hum_q   <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tfail_q <= tfail_d;
      temp_q  <= temp_d;
      hum_q   <= hum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hi_q   <= hi_d;
      prod_q <= prod_d;
    end
  end

  assign last_o            = (pos_eff == POS_H_CRC);
  assign res_o.temperature = temp_q;
  assign res_o.humidity    = hum_take ? quot[13:0] : hum_q;
  assign res_o.status      = tfail_q ? STATUS_TEMP_CRC : (match ? STATUS_OK : STATUS_HUM_CRC);

endmodule

### hdl/humidity_temp_frame_decoder.sv
// top level of the humidity/temperature measurement frame decoder
// Takes the six-byte sensor frame one byte per beat (temperature msb, lsb,
// crc, humidity msb, lsb, crc), checks each crc-8 (poly 0x31, init 0xff) and
// after the sixth byte delivers one result beat with the held temperature in
// hundredths of a degree, the held humidity in hundredths of a percent and a
// status. frame_start_i restarts the frame at the temperature msb. One byte is
// taken every cycle; a byte passes an input register and then the decode
// logic into the output register, which presents the result of each sixth
// byte and holds it there for as long as the sink keeps it stalled. The
// input stalls only when a sixth byte reaches the decode stage while the
// output register still holds a result that the sink is stalling; bytes that
// produce no result keep flowing even then. The scaling multiply is done when
// the lsb of a word arrives and the divide by 65535 (shift and add) when its
// crc arrives, so no path holds more than one multiply or one wide add.
module humidity_temp_frame_decoder import hfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] temperature_o,
  output logic [13:0]        humidity_o,
  output logic [1:0]         status_o
);

  // input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        start_q;
  logic        in_load;

  // decode stage
  logic        step;
  logic        last;
  hfd_result_t res;

  // output register
  logic        out_valid_q, out_valid_d;
  hfd_result_t out_q;
  logic        out_load;

  // a byte with no result always moves on; the sixth needs a free output slot
  assign step       = in_valid_q && (!last || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_load    = in_valid_i && !in_stall_o;
  assign out_load   = step && last;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  hfd_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .start_i(start_q),
    .last_o (last),
    .res_o  (res)
  );

  assign out_valid_o   = out_valid_q;
  assign temperature_o = out_q.temperature;
  assign humidity_o    = out_q.humidity;
  assign status_o      = out_q.status;

`ifndef SYNTHESIS
  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3))
    else $error("undefined status code");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (($signed(temperature_o) >= TEMP_MIN) &&
                     ($signed(temperature_o) <= TEMP_MAX)))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (humidity_o <= HUM_MAX))
    else $error("humidity out of range");
`endif

endmodule

### test/tb_humidity_temp_frame_decoder.sv
// testbench for the humidity/temperature frame decoder: random frames checked against a local decoder
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder;
  import hfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BEATS = 1600;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef struct {
    logic [7:0] value;
    logic       start;
    logic       hold;   // wait for all outstanding readings before sending
  } byte_beat_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] temperature;
  logic [13:0]        humidity;
  logic [1:0]         status;

  byte_beat_t  pending_q[$];
  hfd_result_t readings_q[$];

  // decoder state mirrored by the testbench
  logic [2:0]         fd_pos = POS_T_MSB;
  logic [7:0]         fd_crc = CRC_INIT;
  logic [7:0]         fd_hi = 8'h00;
  logic [7:0]         fd_lo = 8'h00;
  logic               fd_temp_bad = 1'b0;
  logic signed [14:0] fd_temp = '0;
  logic [13:0]        fd_hum = '0;

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  bit          in_took = 1'b0;
  bit          send_burst = 1'b0;
  bit          sink_burst = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  humidity_temp_frame_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .temperature_o (temperature),
    .humidity_o    (humidity),
    .status_o      (status)
  );

  always #10 clk = ~clk;

  // crc-8, poly 0x31, fed one data bit at a time msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // raw sensor word with extra weight on the ends of the range
  function automatic logic [15:0] pick_raw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    if (r < 15) return 16'($urandom_range(0, 15));
    if (r < 20) return 16'($urandom_range(16'hFFF0, 16'hFFFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // advance the mirrored decoder by one accepted byte, queue a reading on the sixth
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [2:0]  pos;
    logic [15:0] raw;
    logic [31:0] scaled;
    logic        match;
    int          t;
    hfd_result_t r;
    pos = fd_pos;
    // frame start, or an impossible position, restarts at the temperature msb
    if (start || pos > POS_H_CRC) begin
      pos = POS_T_MSB;
      fd_crc = CRC_INIT;
    end
    case (pos)
      POS_T_MSB, POS_H_MSB: begin
        fd_crc = crc8_step(CRC_INIT, b);
        fd_hi = b;
      end
      POS_T_LSB, POS_H_LSB: begin
        fd_crc = crc8_step(fd_crc, b);
        fd_lo = b;
      end
      POS_T_CRC: begin
        raw = {fd_hi, fd_lo};
        if (fd_crc == b) begin
          scaled = (32'(TEMP_SCALE) * 32'(raw)) / 32'd65535;
          t = int'(scaled) - int'(TEMP_OFFSET);
          fd_temp = t[14:0];
          fd_temp_bad = 1'b0;
        end else begin
          fd_temp_bad = 1'b1;
        end
        fd_crc = CRC_INIT;
      end
      default: begin
        raw = {fd_hi, fd_lo};
        match = (fd_crc == b);
        // humidity only counts when the temperature word of this frame was good
        if (!fd_temp_bad && match) begin
          scaled = (32'(HUM_SCALE) * 32'(raw)) / 32'd65535;
          fd_hum = scaled[13:0];
        end
        fd_crc = CRC_INIT;
        r.temperature = fd_temp;
        r.humidity = fd_hum;
        r.status = fd_temp_bad ? STATUS_TEMP_CRC : (match ? STATUS_OK : STATUS_HUM_CRC);
        readings_q.push_back(r);
      end
    endcase
    fd_pos = (pos >= POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
  endtask

  task automatic push_beat(input logic [7:0] value, input logic start, input logic hold);
    byte_beat_t bb;
    bb.value = value;
    bb.start = start;
    bb.hold = hold;
    pending_q.push_back(bb);
  endtask

  // six-byte frame, either crc optionally corrupted
  task automatic push_frame(input logic [15:0] t_raw, input logic [15:0] h_raw, input bit t_bad,
                            input bit h_bad, input logic start, input logic hold);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = crc8_step(crc8_step(CRC_INIT, t_raw[15:8]), t_raw[7:0]);
    hc = crc8_step(crc8_step(CRC_INIT, h_raw[15:8]), h_raw[7:0]);
    if (t_bad) tc ^= 8'($urandom_range(1, 255));
    if (h_bad) hc ^= 8'($urandom_range(1, 255));
    push_beat(t_raw[15:8], start, hold);
    push_beat(t_raw[7:0], 1'b0, 1'b0);
    push_beat(tc, 1'b0, 1'b0);
    push_beat(h_raw[15:8], 1'b0, 1'b0);
    push_beat(h_raw[7:0], 1'b0, 1'b0);
    push_beat(hc, 1'b0, 1'b0);
  endtask

  task automatic note_mismatch(input string what);
    errors++;
    if (errors <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // driver: presents the next pending byte at the falling edge once the last one was taken
  always @(negedge clk) begin
    byte_beat_t nxt;
    logic       drive;
    if (rst_ni && (!in_valid || in_took)) begin
      in_took = 1'b0;
      drive = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_q.size() > 0 && !(pending_q[0].hold && readings_q.size() != 0)) begin
        nxt = pending_q.pop_front();
        drive = 1'b1;
        rx_byte <= nxt.value;
        frame_start <= nxt.start;
        // occasionally switch between gappy traffic and back-to-back bursts
        if ($urandom_range(0, 199) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : pick_gap();
      end
      in_valid <= drive;
    end
  end

  // sink: random stall stretches, with quiet stretches of no stall at all
  always @(negedge clk) begin
    int unsigned n;
    if (rst_ni) begin
      if ($urandom_range(0, 299) == 0) sink_burst = !sink_burst;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        n = (sink_burst || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
        if (n > 0) stall_left = n - 1;
        out_stall <= (n > 0);
      end
    end
  end

  // monitor: predicts on each accepted input beat, checks each accepted result beat
  always @(posedge clk) begin
    hfd_result_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        decode_byte(rx_byte, frame_start);
        in_took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (readings_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                  temperature, humidity, status));
        end else begin
          want = readings_q.pop_front();
          if (temperature !== want.temperature || humidity !== want.humidity ||
              status !== want.status) begin
            note_mismatch($sformatf("got %0d/%0d/%0d expected %0d/%0d/%0d",
                                    temperature, humidity, status,
                                    want.temperature, want.humidity, want.status));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_humidity_temp_frame_decoder failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned n;
    logic        hold;

    // directed: raw word extremes, frame wrap without start, restart mid-frame,
    // temperature crc failure (humidity left alone), humidity crc failure
    push_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
    push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    push_beat(8'h12, 1'b1, 1'b0);
    push_beat(8'h34, 1'b0, 1'b0);
    push_frame(16'h8000, 16'h1234, 1'b1, 1'b0, 1'b1, 1'b1);
    push_frame(16'h6666, 16'hABCD, 1'b0, 1'b1, 1'b0, 1'b0);

    // random: mostly well-formed frames, some cut short, some loose noise
    while (pending_q.size() < RANDOM_BEATS + 26) begin
      r = $urandom_range(0, 99);
      hold = ($urandom_range(0, 99) < 2);
      if (r < 80) begin
        push_frame(pick_raw(), pick_raw(), $urandom_range(0, 99) < 12,
                   $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 70, hold);
      end else if (r < 90) begin
        n = $urandom_range(1, 5);
        push_beat(8'($urandom_range(0, 255)), 1'b1, hold);
        for (int i = 1; i < n; i++) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (readings_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_humidity_temp_frame_decoder passed");
    end else begin
      $display("tb_humidity_temp_frame_decoder failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/hfd_pkg.sv
hdl/hfd_frame.sv
hdl/humidity_temp_frame_decoder.sv
test/tb_humidity_temp_frame_decoder.sv
